FILE: hw/rtl/windowed_latency_average_unit_macros.svh
// Assertion macros used by the port-level checker.
`ifndef WINDOWED_LATENCY_AVERAGE_UNIT_MACROS_SVH
`define WINDOWED_LATENCY_AVERAGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WLAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WLAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/wlau_pkg.sv
`default_nettype none

package wlau_pkg;

    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int OP_W             = 2;
    localparam int SAMPLE_W         = 16;
    localparam int AVG_W            = 10;
    localparam int INTERVAL_W       = 16;
    localparam int INTERVAL_RESET   = 16;
    localparam int SAMPLE_MAX       = 999;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample_ms;
    } item_t;

    typedef struct packed {
        logic [AVG_W-1:0] average_ms;
    } result_t;

    typedef logic [INTERVAL_W-1:0] cfg_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wlau_stream_if.sv
`default_nettype none

// Valid/ready channel; a transfer happens when valid and ready are both high.
interface wlau_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/windowed_latency_average_unit.sv
// Channel | Dir | Payload                      | Transfer
// item    | in  | op, sample_ms                | item.valid & item.ready
// result  | out | average_ms                   | result.valid & result.ready
// cfg     | in  | write_interval (16 bit data) | cfg.valid & cfg.ready
//
// Record steps through transfer, ring read and sum/ring update (one ring port).
// A tick that ends the interval with samples in the window also runs the
// bit-serial divider; clear and unused op stay in the idle state.
// Reset clears all counters at once; the ring needs no clearing pass, since
// fill_reg tells which entries hold samples.
// A pending result waits in an output register; item is accepted meanwhile,
// but a new average waits in the finish state until the register is free.
`default_nettype none

module windowed_latency_average_unit #(
    parameter int WINDOW_DEPTH = wlau_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    wlau_stream_if.sink   item,
    wlau_stream_if.source result,
    wlau_stream_if.sink   cfg
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = $clog2(wlau_pkg::SAMPLE_MAX * WINDOW_DEPTH + 1);
    localparam int AVG_W  = wlau_pkg::AVG_W;
    localparam int IVL_W  = wlau_pkg::INTERVAL_W;

    wlau_pkg::state_t      state_reg, state_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [IVL_W-1:0]      tick_reg, tick_next;
    logic [AVG_W-1:0]      last_reg, last_next;
    logic [IVL_W-1:0]      interval_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [AVG_W-1:0]      out_avg_reg;
    logic [AVG_W-1:0]      sample_reg;
    logic [AVG_W-1:0]      rd_data_reg;

    logic [AVG_W-1:0]      ring [WINDOW_DEPTH];

    wlau_pkg::item_t       item_data;
    logic                  item_xfer;
    logic [AVG_W-1:0]      clamped;
    logic [IVL_W-1:0]      tick_inc;
    logic                  full;
    logic [AVG_W-1:0]      old_value;
    logic                  ring_we;
    logic                  ring_re;
    logic                  div_start;
    logic                  out_load;
    logic [AVG_W-1:0]      avg;
    wlau_pkg::div_status_t div_status;
    logic [SUM_W-1:0]      div_quotient;

    assign item_data = item.payload;
    assign item.ready = (state_reg == wlau_pkg::ST_IDLE);
    assign item_xfer = item.valid && item.ready;
    assign cfg.ready = 1'b1;

    // Clamp sample into 0..999
    always_comb
    begin
        priority if (item_data.sample_ms[wlau_pkg::SAMPLE_W-1])
        begin
            clamped = '0;
        end
        else if (item_data.sample_ms > wlau_pkg::SAMPLE_W'(wlau_pkg::SAMPLE_MAX))
        begin
            clamped = AVG_W'(wlau_pkg::SAMPLE_MAX);
        end
        else
        begin
            clamped = item_data.sample_ms[AVG_W-1:0];
        end
    end

    // Entries beyond the fill count were never written since the last clear
    assign full      = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign old_value = full ? rd_data_reg : '0;
    assign tick_inc  = tick_reg + IVL_W'(1);
    assign avg       = div_quotient[AVG_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        fill_next      = fill_reg;
        tick_next      = tick_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ring_we        = 1'b0;
        ring_re        = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            wlau_pkg::ST_IDLE:
            begin
                if (item_xfer)
                begin
                    unique case (item_data.op)
                        wlau_pkg::OP_RECORD:
                        begin
                            ring_re    = 1'b1;
                            state_next = wlau_pkg::ST_READ;
                        end
                        wlau_pkg::OP_TICK:
                        begin
                            if (tick_inc < interval_reg)
                            begin
                                tick_next = tick_inc;
                            end
                            else
                            begin
                                tick_next = '0;
                                if (fill_reg != '0)
                                begin
                                    div_start  = 1'b1;
                                    state_next = wlau_pkg::ST_DIVIDE;
                                end
                            end
                        end
                        wlau_pkg::OP_CLEAR:
                        begin
                            slot_next = '0;
                            sum_next  = '0;
                            fill_next = '0;
                            tick_next = '0;
                            last_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            wlau_pkg::ST_READ:
            begin
                state_next = wlau_pkg::ST_UPDATE;
            end
            wlau_pkg::ST_UPDATE:
            begin
                ring_we  = 1'b1;
                sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(sample_reg);
                if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                state_next = wlau_pkg::ST_IDLE;
            end
            wlau_pkg::ST_DIVIDE:
            begin
                if (div_status.done)
                begin
                    state_next = wlau_pkg::ST_FINISH;
                end
            end
            wlau_pkg::ST_FINISH:
            begin
                if (avg == last_reg)
                begin
                    state_next = wlau_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = avg;
                    state_next     = wlau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wlau_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wlau_pkg::ST_IDLE;
            slot_reg      <= '0;
            sum_reg       <= '0;
            fill_reg      <= '0;
            tick_reg      <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
            interval_reg  <= IVL_W'(wlau_pkg::INTERVAL_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            fill_reg      <= fill_next;
            tick_reg      <= tick_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                interval_reg <= cfg.payload;
            end
        end
    end

    // Payload registers and sample ring
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            sample_reg <= clamped;
        end
        if (out_load)
        begin
            out_avg_reg <= avg;
        end
        if (ring_re)
        begin
            rd_data_reg <= ring[slot_reg];
        end
        if (ring_we)
        begin
            ring[slot_reg] <= sample_reg;
        end
    end

    wlau_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (fill_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign result.valid              = out_valid_reg;
    assign result.payload.average_ms = out_avg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wlau_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module wlau_div #(
    parameter int DIVIDEND_W = 14,
    parameter int DIVISOR_W  = 5
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output wlau_pkg::div_status_t      status,
    output logic      [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, divisor_reg};
        fits  = (trial >= {1'b0, divisor_reg});
    end

    // Step control
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            divisor_reg <= divisor;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/wlau_checker.sv
`default_nettype none
`include "windowed_latency_average_unit_macros.svh"

// Port-level checks for the latency average unit.
module wlau_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           item_valid,
    input wire logic                           item_ready,
    input wire logic [wlau_pkg::OP_W-1:0]      item_op,
    input wire logic                           result_valid,
    input wire logic                           result_ready,
    input wire logic [wlau_pkg::AVG_W-1:0]     result_avg
);

    // A pending result stays until taken
    `WLAU_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid)

    // A recorded sample keeps the block busy for the ring update
    `WLAU_ASSERT_NEXT(a_record_busy, clk, rst_n,
        item_valid && item_ready && (item_op == wlau_pkg::OP_RECORD), !item_ready)

    // A new result only comes out of a divide, never straight from idle
    `WLAU_ASSERT_IMPLY(a_result_from_divide, clk, rst_n,
        $rose(result_valid), !$past(item_ready))

    // Averages stay within the clamp range
    `WLAU_ASSERT_IMPLY(a_result_range, clk, rst_n,
        result_valid, result_avg <= wlau_pkg::AVG_W'(wlau_pkg::SAMPLE_MAX))

endmodule

bind windowed_latency_average_unit wlau_checker u_wlau_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.payload.op),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_avg   (result.payload.average_ms)
);

`default_nettype wire

FILE: bench/latency_average_checker.sv
`default_nettype none

// Watches the item, cfg and result channels, predicts the windowed average
// and compares each result transfer against the oldest pending prediction.
module latency_average_checker
    import wlau_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item_data,
    input  wire logic    avg_valid,
    input  wire logic    avg_ready,
    input  wire result_t avg_data,
    input  wire logic    cfg_valid,
    input  wire logic    cfg_ready,
    input  wire cfg_t    cfg_data,
    output int           mismatches,
    output int           outstanding,
    output int           compared
);

    localparam int DEPTH        = WINDOW_DEPTH_DEF;
    localparam int SLOT_W       = $clog2(DEPTH);
    localparam int SUM_W        = $clog2(DEPTH * SAMPLE_MAX + 1);
    localparam int FILL_W       = $clog2(DEPTH + 1);
    localparam int REPORT_LIMIT = 10;

    // Predictor state
    logic [AVG_W-1:0]      ring_ms [DEPTH];
    logic [SLOT_W-1:0]     next_slot;
    logic [SUM_W-1:0]      sum_ms;
    logic [FILL_W-1:0]     fill;
    logic [INTERVAL_W-1:0] tick_cnt;
    logic [INTERVAL_W-1:0] interval;
    logic [AVG_W-1:0]      last_avg;

    // Averages predicted but not yet seen on the result channel
    logic [AVG_W-1:0]      pending_averages [$];
    logic [AVG_W-1:0]      oldest_avg;
    int                    err_cnt;
    int                    cmp_cnt;

    task automatic clear_window();
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_ms[i] = '0;
        end
        next_slot = '0;
        sum_ms    = '0;
        fill      = '0;
        tick_cnt  = '0;
        last_avg  = '0;
    endtask

    // Clamp to 0..999 and overwrite the oldest entry
    task automatic record_sample(input logic signed [SAMPLE_W-1:0] raw);
        int               s;
        logic [AVG_W-1:0] v;
        s = $signed(raw);
        if (s < 0)
            v = '0;
        else if (s > SAMPLE_MAX)
            v = AVG_W'(SAMPLE_MAX);
        else
            v = AVG_W'(s);
        sum_ms             = sum_ms - SUM_W'(ring_ms[next_slot]) + SUM_W'(v);
        ring_ms[next_slot] = v;
        next_slot          = next_slot + 1'b1;
        if (fill < FILL_W'(DEPTH))
            fill = fill + 1'b1;
    endtask

    // Advance the interval counter; emit the mean only when it changed
    task automatic tick_interval();
        logic [AVG_W-1:0] avg;
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= interval)
        begin
            tick_cnt = '0;
            if (fill != 0)
            begin
                avg = AVG_W'(sum_ms / fill);
                if (avg != last_avg)
                begin
                    last_avg = avg;
                    pending_averages.push_back(avg);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            interval = INTERVAL_W'(INTERVAL_RESET);
            pending_averages.delete();
            err_cnt = 0;
            cmp_cnt = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                interval = cfg_data;

            // Result transfer: compare against the oldest prediction
            if (avg_valid && avg_ready)
            begin
                if (pending_averages.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_LIMIT)
                        $display("unexpected average %0d with nothing pending",
                                 avg_data.average_ms);
                end
                else
                begin
                    oldest_avg = pending_averages.pop_front();
                    cmp_cnt++;
                    if (avg_data.average_ms !== oldest_avg)
                    begin
                        err_cnt++;
                        if (err_cnt <= REPORT_LIMIT)
                            $display("average_ms mismatch: expected %0d, got %0d",
                                     oldest_avg, avg_data.average_ms);
                    end
                end
            end

            // Item transfer: update the predictor
            if (item_valid && item_ready)
            begin
                case (item_data.op)
                    OP_RECORD: record_sample(item_data.sample_ms);
                    OP_TICK:   tick_interval();
                    OP_CLEAR:  clear_window();
                    default:   ;
                endcase
            end
        end
        mismatches  <= err_cnt;
        outstanding <= pending_averages.size();
        compared    <= cmp_cnt;
    end

endmodule

`default_nettype wire

FILE: bench/tb_windowed_latency_average_unit.sv
`default_nettype none

module tb_windowed_latency_average_unit;
    import wlau_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 80;
    localparam int IDLE_PCT     = 37;

    logic clk = 1'b0;
    logic rst_n;
    logic steady;

    int mismatches;
    int outstanding;
    int compared;
    int n_rec;
    int n_tick;
    int n_clr;
    int n_none;
    int n_cfg;

    wlau_stream_if #(.payload_t(item_t))   item_if ();
    wlau_stream_if #(.payload_t(result_t)) avg_if ();
    wlau_stream_if #(.payload_t(cfg_t))    cfg_if ();

    windowed_latency_average_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (avg_if),
        .cfg    (cfg_if)
    );

    latency_average_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_if.valid),
        .item_ready  (item_if.ready),
        .item_data   (item_if.payload),
        .avg_valid   (avg_if.valid),
        .avg_ready   (avg_if.ready),
        .avg_data    (avg_if.payload),
        .cfg_valid   (cfg_if.valid),
        .cfg_ready   (cfg_if.ready),
        .cfg_data    (cfg_if.payload),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    always #5 clk = ~clk;

    // Result sink: random stalls unless in the steady stretch
    always @(posedge clk)
    begin
        avg_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // One item transfer, with random idle cycles in front
    task automatic send_item(input op_t op, input logic signed [SAMPLE_W-1:0] smp);
        item_t it;
        it.op        = op;
        it.sample_ms = smp;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.payload <= it;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        case (op)
            OP_RECORD: n_rec++;
            OP_TICK:   n_tick++;
            OP_CLEAR:  n_clr++;
            default:   n_none++;
        endcase
    endtask

    // Hold off the sender until every predicted average has arrived
    task automatic wait_for_averages();
        item_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Interval write while the block is idle
    task automatic set_interval(input cfg_t v);
        wait_for_averages();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        n_cfg++;
    endtask

    // Mostly in-range latencies, some raw 16-bit values and clamp corners
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        if (r < 90)
            return SAMPLE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return -16'sd1;
            default: return 16'sd1000;
        endcase
    endfunction

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52)
            send_item(OP_RECORD, rand_sample());
        else if (r < 95)
            send_item(OP_TICK, SAMPLE_W'($urandom));
        else if (r < 98)
            send_item(OP_CLEAR, SAMPLE_W'($urandom));
        else
            send_item(OP_NONE, SAMPLE_W'($urandom));
    endtask

    initial
    begin
        int intervals [5];
        item_if.valid   = 1'b0;
        item_if.payload = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.payload  = '0;
        avg_if.ready    = 1'b0;
        steady          = 1'b0;
        rst_n           = 1'b0;
        n_rec           = 0;
        n_tick          = 0;
        n_clr           = 0;
        n_none          = 0;
        n_cfg           = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty window, zero average, clamping, unused op, clear
        set_interval(16'd1);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sd0);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sh8000);
        send_item(OP_RECORD, 16'sh7fff);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_NONE,   16'sh7fff);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sd1000);
        send_item(OP_RECORD, 16'sd999);
        send_item(OP_RECORD, 16'sd500);
        send_item(OP_RECORD, -16'sd1);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_CLEAR,  16'sd0);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sd1);
        send_item(OP_TICK,   16'sd0);

        // Zero interval: every tick is a chance to emit
        set_interval(16'd0);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sd3);
        send_item(OP_TICK,   16'sd0);

        // Largest interval, then lowered below the running count
        set_interval(16'hffff);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_TICK,   16'sd0);
        send_item(OP_RECORD, 16'sd8);
        set_interval(16'd1);
        send_item(OP_TICK,   16'sd0);

        // Random phases over several intervals; phase 2 runs without idling
        intervals = '{1, 3, 0, $urandom_range(2, 6), 2};
        foreach (intervals[p])
        begin
            set_interval(cfg_t'(intervals[p]));
            steady <= (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == PHASE_ITEMS / 2)
                    wait_for_averages();
                send_random_item();
            end
        end
        steady <= 1'b0;

        // Drain
        wait_for_averages();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d records, %0d ticks, %0d clears, %0d unused ops, %0d interval writes",
                 n_rec, n_tick, n_clr, n_none, n_cfg);
        $display("Averages compared: %0d, mismatches: %0d, still pending: %0d",
                 compared, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/wlau_pkg.sv
hw/rtl/wlau_stream_if.sv
hw/rtl/wlau_div.sv
hw/rtl/windowed_latency_average_unit.sv
hw/rtl/wlau_checker.sv
bench/latency_average_checker.sv
bench/tb_windowed_latency_average_unit.sv
